@@ rtl/core/aes_pkg.sv @@
// ============================================================================
// AES-128 shared definitions
// S-boxes, round constants, GF(2^8) helpers and the round transforms used by
// the key cells and the round cells.
// ============================================================================
`default_nettype none

package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW = 64;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned SettleW = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 8'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLow = 8'd1;

  // Command codes carried in tuser.
  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  typedef logic [BlockW-1:0] block_t;

  // Control that travels beside the block from cell to cell.
  typedef struct packed {
    logic valid;
    logic cmd;
  } ctl_t;

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] FWD_COEF [4] = '{8'h02, 8'h03, 8'h01, 8'h01};
  localparam logic [7:0] INV_COEF [4] = '{8'h0e, 8'h0b, 8'h0d, 8'h09};

  // Byte i of a block sits in bits 127-8i down to 120-8i.
  function automatic logic [7:0] get_byte(input block_t s, input int unsigned i);
    get_byte = s[BlockW-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Multiply by a constant coefficient; folds to a few XORs in synthesis.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gf_mul = p;
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(c*4+r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t inv_shift_sub(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(((c + r) % 4) * 4 + r) -: 8] = INV_SBOX[get_byte(s, c*4 + r)];
      end
    end
    inv_shift_sub = t;
  endfunction

  function automatic block_t mix_fwd(input block_t s);
    block_t t;
    logic [7:0] acc;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gf_mul(get_byte(s, c*4 + k), FWD_COEF[(k - r + 4) % 4]);
        end
        t[BlockW-1-8*(c*4+r) -: 8] = acc;
      end
    end
    mix_fwd = t;
  endfunction

  function automatic block_t mix_inv(input block_t s);
    block_t t;
    logic [7:0] acc;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gf_mul(get_byte(s, c*4 + k), INV_COEF[(k - r + 4) % 4]);
        end
        t[BlockW-1-8*(c*4+r) -: 8] = acc;
      end
    end
    mix_inv = t;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/aes_key_cell.sv @@
// ============================================================================
// AES-128 key expansion cell
// Registers the next round key from the previous one: one schedule step.
// ============================================================================
`default_nettype none

module aes_key_cell (
  input  wire logic            clk,
  input  wire logic [7:0]      rcon,
  input  wire aes_pkg::block_t key_in,
  output      aes_pkg::block_t key_out
);
  import aes_pkg::*;

  logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;

  // RotWord, SubWord and the round constant on the last word.
  always_comb begin
    w0 = key_in[127:96];
    w1 = key_in[95:64];
    w2 = key_in[63:32];
    w3 = key_in[31:0];
    t  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
  end

  always_ff @(posedge clk) begin
    key_out <= {n0, n1, n2, n3};
  end

endmodule

`default_nettype wire

@@ rtl/core/aes_round_cell.sv @@
// ============================================================================
// AES-128 round cell
// One forward or inverse cipher round, registered, passed on to the next cell.
// ============================================================================
`default_nettype none

module aes_round_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            last_round,
  input  wire aes_pkg::ctl_t   ctl_in,
  input  wire aes_pkg::block_t state_in,
  input  wire aes_pkg::block_t rk_enc,
  input  wire aes_pkg::block_t rk_dec,
  output      aes_pkg::ctl_t   ctl_out,
  output      aes_pkg::block_t state_out
);
  import aes_pkg::*;

  block_t enc_a, dec_a, state_next;

  // Encrypt: SubBytes, ShiftRows, MixColumns (not in the last round), AddRoundKey.
  // Decrypt: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns (not in the last round).
  always_comb begin
    enc_a = sub_shift(state_in);
    if (!last_round) enc_a = mix_fwd(enc_a);
    enc_a = enc_a ^ rk_enc;
    dec_a = inv_shift_sub(state_in) ^ rk_dec;
    if (!last_round) dec_a = mix_inv(dec_a);
    state_next = (ctl_in.cmd == CmdDecrypt) ? dec_a : enc_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_out <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/aes128_block_cipher_top.sv @@
// ============================================================================
// AES-128 block cipher
// Unrolled chain of ten round cells fed by a chain of ten key cells.
// ============================================================================
// Stages: a key add stage plus 10 round stages, each one registered.
// Throughput: one item per cycle; the whole chain holds while a result waits.
// After reset and after every key write, s_axis_tready stays low until the settle
// counter runs out, while the key cells settle the round keys. Keys reset to zero.
`default_nettype none

module aes128_block_cipher_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [aes_pkg::BlockW-1:0]    s_axis_tdata,  // data_high, data_low
  input  wire logic                          s_axis_tuser,  // cmd
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [aes_pkg::BlockW-1:0]    m_axis_tdata,  // result_high, result_low
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [aes_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [aes_pkg::HalfW-1:0]     cfg_data
);
  import aes_pkg::*;

  logic [HalfW-1:0]   key_high, key_low;
  logic [SettleW-1:0] settle;
  block_t             rkey [NumRounds+1];
  ctl_t               ctl [NumRounds+1];
  block_t             st [NumRounds+1];
  ctl_t               ctl0_next;
  block_t             st0_next;
  logic               adv;

  assign cfg_ready = 1'b1;

  // Key registers and the settle counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      settle   <= SettleW'(NumRounds);
    end else if (cfg_valid) begin
      if (cfg_index == RegKeyHigh) key_high <= cfg_data;
      if (cfg_index == RegKeyLow) key_low <= cfg_data;
      settle <= SettleW'(NumRounds);
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  // Key schedule chain.
  assign rkey[0] = {key_high, key_low};
  for (genvar g = 0; g < NumRounds; g++) begin : g_key
    aes_key_cell u_key (
      .clk     (clk),
      .rcon    (RCON[g]),
      .key_in  (rkey[g]),
      .key_out (rkey[g+1])
    );
  end

  // Chain advances unless the last cell holds a result not yet taken.
  assign adv           = !(ctl[NumRounds].valid && !m_axis_tready);
  assign s_axis_tready = adv && (settle == '0);

  // Entry stage: initial AddRoundKey.
  always_comb begin
    ctl0_next.valid = s_axis_tvalid && s_axis_tready;
    ctl0_next.cmd   = s_axis_tuser;
    st0_next = {s_axis_tdata[HalfW-1:0], s_axis_tdata[BlockW-1:HalfW]} ^
               ((s_axis_tuser == CmdDecrypt) ? rkey[NumRounds] : rkey[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (adv) begin
      ctl[0] <= ctl0_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= st0_next;
    end
  end

  // Round chain.
  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    aes_round_cell u_round (
      .clk        (clk),
      .rst        (rst),
      .en         (adv),
      .last_round (g == NumRounds),
      .ctl_in     (ctl[g-1]),
      .state_in   (st[g-1]),
      .rk_enc     (rkey[g]),
      .rk_dec     (rkey[NumRounds-g]),
      .ctl_out    (ctl[g]),
      .state_out  (st[g])
    );
  end

  assign m_axis_tvalid = ctl[NumRounds].valid;
  assign m_axis_tdata  = {st[NumRounds][HalfW-1:0], st[NumRounds][BlockW-1:HalfW]};

endmodule

`default_nettype wire
